// ===== rtl/core/tdcphe_pkg.sv =====
// Shared types, codes and helpers for the TDC packet hit extractor.
// No dependencies; imported by every module of the block except tdcphe_ram.
package tdcphe_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int PCW         = 7;
  localparam int TS_W        = 64;
  localparam int HW_W        = 32;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 200;
  localparam int QDEPTH      = 2;

  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_HIT    = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic KIND_HIT = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  localparam logic [1:0] CFG_PKT_MASK = 2'd0;
  localparam logic [1:0] CFG_HIT_MASK = 2'd1;
  localparam logic [1:0] CFG_MAX_HITS = 2'd2;

  localparam logic [7:0] MARK_PATTERN = 8'h2f;
  localparam logic [7:0] HIT_ERR_BITS = 8'hf0;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef struct packed {
    logic            is_sum;
    logic [PCW-1:0]  words;
    logic [PCW-1:0]  hits;
    logic [TS_W-1:0] ts;
    logic [1:0]      status;
    cnt_t            total;
    cnt_t            valid;
    cnt_t            errs;
    cnt_t            empty;
  } cmd_t;

  typedef struct packed {
    logic drain_done;
  } back_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EVAL
  } bk_state_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (&c) ? c : cnt_t'(c + 1'b1);
  endfunction

  function automatic logic is_marker(input logic [HW_W-1:0] w);
    return (w[7:0] & MARK_PATTERN) == MARK_PATTERN;
  endfunction

endpackage

// ===== rtl/core/tdc_packet_hit_extractor.sv =====
// Top level of the TDC packet hit extractor: front end, command queue, hit RAM, back end.
// Depends on tdcphe_pkg, tdcphe_front, tdcphe_cmdq, tdcphe_ram and tdcphe_back.
//
// Headers, hit words and finish beats are taken at one per cycle by the front end while in_tready is high.
// When the last hit word of a good packet with at least one hit arrives, the back end
// pops the drain command and reads the packet buffer RAM word by word (RAM read, then
// evaluate/emit), stalling on hit records while out_tready is low. Hit words are held
// off (in_tready low) while that drain runs or the two-entry command queue is full;
// finish beats wait only for queue room and headers are never held off. A finish
// beat produces one summary beat once earlier records are out.
module tdc_packet_hit_extractor
  import tdcphe_pkg::*;
#(
  parameter int MAX_PACKET_HITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // packet_length[5:0], packet_flags[13:6], packet_timestamp[77:14], hit_word[109:78]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // hit_time[31:0], channel[35:32], start_timestamp[99:36], status[101:100],
  // total_hits[125:102], valid_packets[149:126], error_packets[173:150],
  // empty_packets[197:174]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic                  out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [23:0]           cfg_data
);

  localparam int AW = $clog2(MAX_PACKET_HITS);

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [HW_W-1:0] wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [HW_W-1:0] rd_data;
  logic            q_push;
  cmd_t            q_in;
  logic            q_full;
  logic            q_pop;
  cmd_t            q_head;
  logic            q_empty;
  back_stat_t      bk_stat;

  tdcphe_front #(
    .MAX_PACKET_HITS(MAX_PACKET_HITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_push    (q_push),
    .q_cmd     (q_in),
    .q_full    (q_full),
    .bk_stat   (bk_stat)
  );

  tdcphe_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  tdcphe_ram #(
    .WIDTH(HW_W),
    .DEPTH(MAX_PACKET_HITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tdcphe_back #(
    .MAX_PACKET_HITS(MAX_PACKET_HITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .bk_stat    (bk_stat)
  );

endmodule

// ===== rtl/core/tdcphe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdcphe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/tdcphe_cmdq.sv =====
// Two-entry command queue between front and back of the hit extractor.
// Depends on tdcphe_pkg.
module tdcphe_cmdq
  import tdcphe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int QAW = $clog2(QDEPTH);

  cmd_t             ent_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? QAW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QAW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head  = ent_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QAW+1)'(QDEPTH));

endmodule

// ===== rtl/core/tdcphe_front.sv =====
// Front end: accepts input beats and config writes, checks packets, buffers hits,
// keeps run counters and queues drain and summary commands. Depends on tdcphe_pkg.
module tdcphe_front
  import tdcphe_pkg::*;
#(
  parameter int MAX_PACKET_HITS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_DATA_W-1:0]               in_tdata,
  input  logic [1:0]                         in_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [23:0]                        cfg_data,
  output logic                               wr_en,
  output logic [$clog2(MAX_PACKET_HITS)-1:0] wr_addr,
  output logic [HW_W-1:0]                    wr_data,
  output logic                               q_push,
  output cmd_t                               q_cmd,
  input  logic                               q_full,
  input  back_stat_t                         bk_stat
);

  localparam int AW = $clog2(MAX_PACKET_HITS);
  localparam logic [PCW-1:0] MAXW = PCW'(MAX_PACKET_HITS);
  localparam logic [PCW-1:0] AMASK = PCW'(MAX_PACKET_HITS - 1);

  logic [7:0]      pmask_r, pmask_nxt;
  logic [7:0]      hmask_r, hmask_nxt;
  cnt_t            max_hits_r, max_hits_nxt;
  logic [PCW-1:0]  exp_r, exp_nxt;
  logic [PCW-1:0]  recv_r, recv_nxt;
  logic [PCW-1:0]  nhit_r, nhit_nxt;
  logic            kept_r, kept_nxt;
  logic            herr_r, herr_nxt;
  logic [TS_W-1:0] ts_r, ts_nxt;
  logic            stop_r, stop_nxt;
  logic [1:0]      status_r, status_nxt;
  cnt_t            total_r, total_nxt;
  cnt_t            vcnt_r, vcnt_nxt;
  cnt_t            ecnt_r, ecnt_nxt;
  cnt_t            mcnt_r, mcnt_nxt;
  logic            drain_pend_r, drain_pend_nxt;

  logic [1:0]      op;
  logic [5:0]      len;
  logic [7:0]      flags;
  logic [TS_W-1:0] pkt_ts;
  logic [HW_W-1:0] word;
  logic            accept;
  logic [PCW-1:0]  hcount;
  logic [24:0]     room;
  logic            too_big;
  logic            no_room;
  logic            herr_any;
  logic [PCW-1:0]  nhit_sum;
  logic [PCW-1:0]  recv_inc;
  logic            bad;

  assign op     = in_tuser;
  assign len    = in_tdata[5:0];
  assign flags  = in_tdata[13:6];
  assign pkt_ts = in_tdata[77:14];
  assign word   = in_tdata[109:78];

  assign in_tready = !(((op == OP_FINISH) && q_full) ||
                       ((op == OP_HIT) && (drain_pend_r || q_full)));
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign hcount   = {len, 1'b0} - {6'b0, flags[0]};
  assign room     = {1'b0, max_hits_r} - {1'b0, total_r};
  assign too_big  = {{(COUNT_WIDTH-PCW){1'b0}}, hcount} > max_hits_r;
  assign no_room  = room[24] || ({{(COUNT_WIDTH-PCW){1'b0}}, hcount} > room[23:0]);
  assign herr_any = herr_r || ((word[7:0] & hmask_r & HIT_ERR_BITS) != 8'h00);
  assign nhit_sum = nhit_r + {{(PCW-1){1'b0}}, !is_marker(word)};
  assign recv_inc = recv_r + 1'b1;
  assign bad      = (len == 6'd0) || ((flags & pmask_r) != 8'h00);

  assign wr_addr = AW'(recv_r & AMASK);
  assign wr_data = word;

  always_comb begin
    pmask_nxt      = pmask_r;
    hmask_nxt      = hmask_r;
    max_hits_nxt   = max_hits_r;
    exp_nxt        = exp_r;
    recv_nxt       = recv_r;
    nhit_nxt       = nhit_r;
    kept_nxt       = kept_r;
    herr_nxt       = herr_r;
    ts_nxt         = ts_r;
    stop_nxt       = stop_r;
    status_nxt     = status_r;
    total_nxt      = total_r;
    vcnt_nxt       = vcnt_r;
    ecnt_nxt       = ecnt_r;
    mcnt_nxt       = mcnt_r;
    drain_pend_nxt = drain_pend_r && !bk_stat.drain_done;
    wr_en          = 1'b0;
    q_push         = 1'b0;
    q_cmd          = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_PKT_MASK: pmask_nxt    = cfg_data[7:0];
        CFG_HIT_MASK: hmask_nxt    = cfg_data[7:0];
        CFG_MAX_HITS: max_hits_nxt = cfg_data;
        default: ;
      endcase
    end

    if (accept) begin
      case (op)
        OP_FINISH: begin
          q_push       = 1'b1;
          q_cmd.is_sum = 1'b1;
          q_cmd.status = status_r;
          q_cmd.total  = total_r;
          q_cmd.valid  = vcnt_r;
          q_cmd.errs   = ecnt_r;
          q_cmd.empty  = mcnt_r;
          exp_nxt      = '0;
          recv_nxt     = '0;
          nhit_nxt     = '0;
          kept_nxt     = 1'b0;
          herr_nxt     = 1'b0;
          ts_nxt       = '0;
          stop_nxt     = 1'b0;
          status_nxt   = ST_OK;
          total_nxt    = '0;
          vcnt_nxt     = '0;
          ecnt_nxt     = '0;
          mcnt_nxt     = '0;
        end
        OP_HEADER: begin
          if (!stop_r) begin
            kept_nxt = 1'b0;
            herr_nxt = 1'b0;
            recv_nxt = '0;
            exp_nxt  = '0;
            nhit_nxt = '0;
            if (len == 6'd0) begin
              mcnt_nxt = sat_inc(mcnt_r);
            end
            if ((flags & pmask_r) != 8'h00) begin
              ecnt_nxt = sat_inc(ecnt_r);
            end
            if (!bad) begin
              if (too_big) begin
                status_nxt = ST_TOO_BIG;
                stop_nxt   = 1'b1;
              end else if (no_room) begin
                status_nxt = ST_FULL;
                stop_nxt   = 1'b1;
              end else begin
                exp_nxt  = (hcount > MAXW) ? MAXW : hcount;
                ts_nxt   = pkt_ts;
                kept_nxt = 1'b1;
              end
            end
          end
        end
        OP_HIT: begin
          if (!stop_r && kept_r && (recv_r < exp_r)) begin
            wr_en    = 1'b1;
            recv_nxt = recv_inc;
            herr_nxt = herr_any;
            nhit_nxt = nhit_sum;
            if (recv_inc == exp_r) begin
              kept_nxt = 1'b0;
              if (herr_any) begin
                ecnt_nxt = sat_inc(ecnt_r);
              end else if (nhit_sum != '0) begin
                vcnt_nxt       = sat_inc(vcnt_r);
                total_nxt      = total_r + {{(COUNT_WIDTH-PCW){1'b0}}, nhit_sum};
                q_push         = 1'b1;
                q_cmd.is_sum   = 1'b0;
                q_cmd.words    = exp_r;
                q_cmd.hits     = nhit_sum;
                q_cmd.ts       = ts_r;
                drain_pend_nxt = 1'b1;
              end else begin
                mcnt_nxt = sat_inc(mcnt_r);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmask_r      <= '0;
      hmask_r      <= '0;
      max_hits_r   <= '1;
      exp_r        <= '0;
      recv_r       <= '0;
      nhit_r       <= '0;
      kept_r       <= 1'b0;
      herr_r       <= 1'b0;
      ts_r         <= '0;
      stop_r       <= 1'b0;
      status_r     <= ST_OK;
      total_r      <= '0;
      vcnt_r       <= '0;
      ecnt_r       <= '0;
      mcnt_r       <= '0;
      drain_pend_r <= 1'b0;
    end else begin
      pmask_r      <= pmask_nxt;
      hmask_r      <= hmask_nxt;
      max_hits_r   <= max_hits_nxt;
      exp_r        <= exp_nxt;
      recv_r       <= recv_nxt;
      nhit_r       <= nhit_nxt;
      kept_r       <= kept_nxt;
      herr_r       <= herr_nxt;
      ts_r         <= ts_nxt;
      stop_r       <= stop_nxt;
      status_r     <= status_nxt;
      total_r      <= total_nxt;
      vcnt_r       <= vcnt_nxt;
      ecnt_r       <= ecnt_nxt;
      mcnt_r       <= mcnt_nxt;
      drain_pend_r <= drain_pend_nxt;
    end
  end

endmodule

// ===== rtl/core/tdcphe_back.sv =====
// Back end: drains buffered packets from the hit RAM with rollover offsets and
// emits hit records and run summaries through an output register. Depends on tdcphe_pkg.
module tdcphe_back
  import tdcphe_pkg::*;
#(
  parameter int MAX_PACKET_HITS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  cmd_t                               q_cmd,
  output logic                               q_pop,
  output logic                               rd_en,
  output logic [$clog2(MAX_PACKET_HITS)-1:0] rd_addr,
  input  logic [HW_W-1:0]                    rd_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [OUT_DATA_W-1:0]              out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast,
  output back_stat_t                         bk_stat
);

  localparam int AW = $clog2(MAX_PACKET_HITS);

  bk_state_t             state_r, state_nxt;
  logic [PCW-1:0]        idx_r, idx_nxt;
  logic [PCW-1:0]        words_r, words_nxt;
  logic [PCW-1:0]        hits_r, hits_nxt;
  logic [PCW-1:0]        sent_r, sent_nxt;
  logic [7:0]            mk_r, mk_nxt;
  logic [TS_W-1:0]       ts_r, ts_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  marker;
  logic [PCW-1:0]        idx_inc;
  logic                  at_end;

  assign out_free = !out_valid_r || out_tready;
  assign marker   = is_marker(rd_data);
  assign idx_inc  = idx_r + 1'b1;
  assign at_end   = (idx_inc == words_r);
  assign rd_addr  = AW'(idx_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && !q_cmd.is_sum) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: state_nxt = BK_EVAL;
      BK_EVAL: begin
        if (marker || out_free) begin
          state_nxt = at_end ? BK_IDLE : BK_READ;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt               = idx_r;
    words_nxt             = words_r;
    hits_nxt              = hits_r;
    sent_nxt              = sent_r;
    mk_nxt                = mk_r;
    ts_nxt                = ts_r;
    out_valid_nxt         = out_valid_r && !out_tready;
    out_data_nxt          = out_data_r;
    out_kind_nxt          = out_kind_r;
    out_last_nxt          = out_last_r;
    q_pop                 = 1'b0;
    rd_en                 = 1'b0;
    bk_stat.drain_done    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.is_sum) begin
            if (out_free) begin
              q_pop         = 1'b1;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_SUM;
              out_last_nxt  = 1'b1;
              out_data_nxt  = {2'b00, q_cmd.empty, q_cmd.errs, q_cmd.valid, q_cmd.total,
                               q_cmd.status, 64'd0, 4'd0, 32'd0};
            end
          end else begin
            q_pop     = 1'b1;
            idx_nxt   = '0;
            sent_nxt  = '0;
            mk_nxt    = '0;
            words_nxt = q_cmd.words;
            hits_nxt  = q_cmd.hits;
            ts_nxt    = q_cmd.ts;
          end
        end
      end
      BK_READ: rd_en = 1'b1;
      BK_EVAL: begin
        if (marker) begin
          mk_nxt             = mk_r + 1'b1;
          idx_nxt            = idx_inc;
          bk_stat.drain_done = at_end;
        end else if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_kind_nxt       = KIND_HIT;
          out_last_nxt       = ((sent_r + 1'b1) == hits_r);
          out_data_nxt       = {2'b00, 96'd0, 2'b00, ts_r, rd_data[3:0],
                                mk_r, rd_data[31:8]};
          sent_nxt           = sent_r + 1'b1;
          idx_nxt            = idx_inc;
          bk_stat.drain_done = at_end;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    words_r    <= words_nxt;
    hits_r     <= hits_nxt;
    sent_r     <= sent_nxt;
    mk_r       <= mk_nxt;
    ts_r       <= ts_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== dv/tdc_packet_hit_extractor_test.sv =====
// Self-checking testbench for tdc_packet_hit_extractor: a queue-fed stream driver,
// a result monitor and a built-in packet/hit predictor compared record by record.
// Depends on tdcphe_pkg and the tdc_packet_hit_extractor RTL.
module tdc_packet_hit_extractor_test;
  import tdcphe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int BUF_DEPTH    = 64;
  localparam int DRAIN_CYCLES = 300;
  localparam int QUIET_LIMIT  = 4000;

  typedef struct {
    bit [1:0]  op;
    bit [5:0]  len;
    bit [7:0]  flags;
    bit [63:0] ts;
    bit [31:0] word;
  } tdc_item_t;

  typedef struct {
    bit        kind;
    bit [31:0] hit_time;
    bit [3:0]  chan;
    bit [63:0] ts;
    bit [1:0]  status;
    bit [23:0] total;
    bit [23:0] valid;
    bit [23:0] errs;
    bit [23:0] empty;
    bit        last;
  } hit_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [23:0]           cfg_data = '0;

  tdc_packet_hit_extractor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  tdc_item_t tdc_stream[$];
  hit_rec_t  records_due[$];
  tdc_item_t cur_item;
  int        beats_issued = 0;
  int        beats_taken = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // predictor state
  bit [7:0]  mask_pkt = 8'h00;
  bit [7:0]  mask_hit = 8'h00;
  bit [23:0] cap_hits = 24'hFFFFFF;
  bit [31:0] buf_words[BUF_DEPTH];
  int        exp_words, rcv_words;
  bit        pkt_open, pkt_err, stopped;
  bit [63:0] pkt_ts;
  bit [1:0]  run_st;
  bit [23:0] n_hits, n_valid, n_err, n_empty;

  function automatic bit [23:0] count_up(input bit [23:0] c);
    return (c == 24'hFFFFFF) ? c : c + 24'd1;
  endfunction

  function automatic void start_run();
    exp_words = 0;
    rcv_words = 0;
    pkt_open  = 1'b0;
    pkt_err   = 1'b0;
    pkt_ts    = '0;
    stopped   = 1'b0;
    run_st    = ST_OK;
    n_hits    = '0;
    n_valid   = '0;
    n_err     = '0;
    n_empty   = '0;
  endfunction

  function automatic void extract_beat(input tdc_item_t it);
    hit_rec_t  r;
    hit_rec_t  batch[$];
    bit [31:0] d, offset;
    bit        bad;
    int        cnt, i;
    r = '{default: 0};
    if (it.op == OP_FINISH) begin
      r.kind   = KIND_SUM;
      r.status = run_st;
      r.total  = n_hits;
      r.valid  = n_valid;
      r.errs   = n_err;
      r.empty  = n_empty;
      r.last   = 1'b1;
      records_due.push_back(r);
      start_run();
      return;
    end
    if (it.op == OP_NOP || stopped)
      return;
    if (it.op == OP_HEADER) begin
      pkt_open  = 1'b0;
      pkt_err   = 1'b0;
      rcv_words = 0;
      exp_words = 0;
      bad = 1'b0;
      if (it.len == 0) begin
        n_empty = count_up(n_empty);
        bad = 1'b1;
      end
      if ((it.flags & mask_pkt) != 0) begin
        n_err = count_up(n_err);
        bad = 1'b1;
      end
      if (bad)
        return;
      cnt = 2 * int'(it.len) - int'(it.flags[0]);
      if (cnt > int'(cap_hits)) begin
        run_st  = ST_TOO_BIG;
        stopped = 1'b1;
      end else if (n_hits > cap_hits || cnt > int'(cap_hits) - int'(n_hits)) begin
        run_st  = ST_FULL;
        stopped = 1'b1;
      end else begin
        exp_words = (cnt > BUF_DEPTH) ? BUF_DEPTH : cnt;
        pkt_ts    = it.ts;
        pkt_open  = 1'b1;
      end
      return;
    end
    // hit word
    if (!pkt_open || rcv_words >= exp_words)
      return;
    buf_words[rcv_words] = it.word;
    rcv_words++;
    if ((it.word[7:0] & mask_hit & HIT_ERR_BITS) != 0)
      pkt_err = 1'b1;
    if (rcv_words < exp_words)
      return;
    pkt_open = 1'b0;
    if (pkt_err) begin
      n_err = count_up(n_err);
      return;
    end
    offset = '0;
    for (i = 0; i < exp_words; i++) begin
      d = buf_words[i];
      if ((d[7:0] & MARK_PATTERN) == MARK_PATTERN) begin
        offset += 32'h0100_0000;
      end else begin
        r = '{default: 0};
        r.kind     = KIND_HIT;
        r.hit_time = {8'h00, d[31:8]} + offset;
        r.chan     = d[3:0];
        r.ts       = pkt_ts;
        batch.push_back(r);
      end
    end
    if (batch.size() > 0) begin
      n_valid = count_up(n_valid);
      n_hits  = n_hits + 24'(batch.size());
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[k])
        records_due.push_back(batch[k]);
    end else begin
      n_empty = count_up(n_empty);
    end
  endfunction

  function automatic void check_field(input string name, input bit [63:0] want,
                                      input bit [63:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // stream driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        extract_beat(cur_item);
        beats_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (tdc_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = tdc_stream.pop_front();
          in_tdata <= {2'b00, cur_item.word, cur_item.ts, cur_item.flags, cur_item.len};
          in_tuser <= cur_item.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    hit_rec_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got.kind     = out_tuser;
        got.hit_time = out_tdata[31:0];
        got.chan     = out_tdata[35:32];
        got.ts       = out_tdata[99:36];
        got.status   = out_tdata[101:100];
        got.total    = out_tdata[125:102];
        got.valid    = out_tdata[149:126];
        got.errs     = out_tdata[173:150];
        got.empty    = out_tdata[197:174];
        got.last     = out_tlast;
        if (records_due.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual kind %0b tdata %h last %0b",
                   $time, got.kind, out_tdata, got.last);
          mismatches++;
        end else begin
          want = records_due.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("hit_time", want.hit_time, got.hit_time);
          check_field("channel", want.chan, got.chan);
          check_field("start_timestamp", want.ts, got.ts);
          check_field("status", want.status, got.status);
          check_field("total_hits", want.total, got.total);
          check_field("valid_packets", want.valid, got.valid);
          check_field("error_packets", want.errs, got.errs);
          check_field("empty_packets", want.empty, got.empty);
          check_field("last", want.last, got.last);
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    $display("tdc_packet_hit_extractor regression: fail");
    $finish;
  end

  function automatic void queue_beat(input bit [1:0] op, input bit [5:0] len,
                                     input bit [7:0] flags, input bit [63:0] ts,
                                     input bit [31:0] word);
    tdc_item_t it;
    it.op    = op;
    it.len   = len;
    it.flags = flags;
    it.ts    = ts;
    it.word  = word;
    tdc_stream.push_back(it);
    beats_issued++;
  endfunction

  function automatic bit [63:0] rand_ts();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_hit(input bit [31:0] word);
    queue_beat(OP_HIT, 6'($urandom), 8'($urandom), rand_ts(), word);
  endfunction

  function automatic void queue_finish();
    queue_beat(OP_FINISH, 6'($urandom), 8'($urandom), rand_ts(), $urandom);
  endfunction

  function automatic void queue_packet(input bit [5:0] len, input bit [7:0] flags,
                                       input int nwords, input int marker_pct,
                                       input int dirty_pct);
    bit [31:0] w;
    queue_beat(OP_HEADER, len, flags, rand_ts(), $urandom);
    repeat (nwords) begin
      w = $urandom;
      if ($urandom_range(99) >= dirty_pct)
        w[7:4] = 4'h0;
      if ($urandom_range(99) < marker_pct)
        w[7:0] = w[7:0] | MARK_PATTERN;
      queue_hit(w);
    end
  endfunction

  task automatic gen_random(input int n_items);
    int made, roll, len, cnt, nw;
    bit [7:0] fl;
    made = 0;
    while (made < n_items) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        queue_beat(OP_NOP, 6'($urandom), 8'($urandom), rand_ts(), $urandom);
      end else if (roll < 8) begin
        queue_hit($urandom);
      end else if (roll < 12) begin
        queue_finish();
        made++;
      end else begin
        roll = $urandom_range(99);
        len = (roll < 8) ? 0 : (roll < 90) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        fl = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
        cnt = 2 * len - int'(fl[0]);
        if (cnt < 0)
          cnt = 0;
        nw = ($urandom_range(99) < 85) ? cnt : $urandom_range(0, cnt + 2);
        queue_packet(6'(len), fl, nw, 12, 20);
        made += 1 + nw;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input bit [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PKT_MASK: mask_pkt = val[7:0];
      CFG_HIT_MASK: mask_hit = val[7:0];
      CFG_MAX_HITS: cap_hits = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (beats_taken != beats_issued || records_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    start_run();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme fields, markers, empty and stray cases, every operation
    queue_beat(OP_HEADER, 6'd1, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    queue_hit(32'hFFFF_FFDF);
    queue_hit(32'h0000_0000);
    queue_beat(OP_HEADER, 6'd2, 8'h01, 64'h0123_4567_89AB_CDEF, 32'h0);
    queue_hit(32'h0000_002F);
    queue_hit(32'hABCD_EF2F);
    queue_hit(32'hFFFF_FF05);
    queue_beat(OP_HEADER, 6'd1, 8'h01, rand_ts(), 32'h0);
    queue_hit(32'h0000_00FF);
    queue_beat(OP_HEADER, 6'd0, 8'h00, 64'h0, 32'h0);
    queue_hit(32'h1234_5678);
    queue_beat(OP_NOP, 6'h3F, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_beat(OP_HEADER, 6'd1, 8'h00, rand_ts(), 32'h0);
    queue_hit(32'h1234_5601);
    queue_beat(OP_HEADER, 6'd1, 8'h80, rand_ts(), 32'h0);
    queue_hit(32'h0000_0110);
    queue_hit(32'h8765_4302);
    queue_finish();
    queue_finish();
    settle();

    // error masks, full capacity, sender idling, one oversize packet
    write_reg(CFG_PKT_MASK, 24'hFE);
    write_reg(CFG_HIT_MASK, 24'h30);
    write_reg(CFG_MAX_HITS, 24'hFFFFFF);
    send_idle_pct = 84;
    gen_random(6);
    queue_packet(6'($urandom_range(33, 63)), 8'($urandom_range(0, 1)),
                 BUF_DEPTH + 1, 0, 0);
    queue_finish();
    settle();

    // small capacity, receiver stalling
    write_reg(CFG_PKT_MASK, 24'h00);
    write_reg(CFG_HIT_MASK, 24'hFF);
    write_reg(CFG_MAX_HITS, 24'd6);
    send_idle_pct  = 0;
    recv_stall_pct = 84;
    gen_random(6);
    queue_finish();
    settle();

    // zero capacity: any good packet is too big
    write_reg(CFG_PKT_MASK, 24'hFF);
    write_reg(CFG_HIT_MASK, 24'h00);
    write_reg(CFG_MAX_HITS, 24'd0);
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    queue_beat(OP_HEADER, 6'd0, 8'h00, rand_ts(), 32'h0);
    queue_beat(OP_HEADER, 6'd63, 8'h00, rand_ts(), 32'h0);
    queue_hit($urandom);
    queue_hit($urandom);
    queue_beat(OP_HEADER, 6'd1, 8'h00, rand_ts(), 32'h0);
    queue_finish();
    settle();

    write_reg(CFG_PKT_MASK, 24'($urandom_range(1, 255)));
    write_reg(CFG_MAX_HITS, 24'($urandom_range(10, 60)));
    gen_random(6);
    queue_finish();
    settle();

    if (mismatches == 0 && records_due.size() == 0)
      $display("tdc_packet_hit_extractor regression: pass");
    else
      $display("tdc_packet_hit_extractor regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tdcphe_pkg.sv
rtl/core/tdcphe_ram.sv
rtl/core/tdcphe_cmdq.sv
rtl/core/tdcphe_front.sv
rtl/core/tdcphe_back.sv
rtl/core/tdc_packet_hit_extractor.sv
dv/tdc_packet_hit_extractor_test.sv
